/* hw/rtl/ibus_frame_receiver_assert.svh */
// ----------------------------------------------------------------------------
// ibus_frame_receiver_assert.svh
// Assertion macros used by the iBUS frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef IBUS_FRAME_RECEIVER_ASSERT_SVH
`define IBUS_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define IFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ibus receiver: assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define IFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ibus receiver: assertion failed");

`endif

/* hw/rtl/ifr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_pkg
// Types and constants of the iBUS frame receiver.
// ----------------------------------------------------------------------------
package ifr_pkg;

    // Frame geometry
    localparam int FRAME_LENGTH = 32;
    localparam int BYTE_IDX_W   = $clog2(FRAME_LENGTH);

    typedef logic [BYTE_IDX_W-1:0] t_byte_idx;

    localparam t_byte_idx  LAST_POS       = t_byte_idx'(FRAME_LENGTH - 1);
    localparam t_byte_idx  HDR_LEN_POS    = t_byte_idx'(0);
    localparam t_byte_idx  HDR_CMD_POS    = t_byte_idx'(1);
    localparam t_byte_idx  FIRST_CHAN_POS = t_byte_idx'(2);
    localparam t_byte_idx  SUM_BYTES      = t_byte_idx'(30);
    localparam t_byte_idx  CSUM_LO_POS    = t_byte_idx'(30);

    // Header and checksum
    localparam logic [7:0]  HDR_LENGTH  = 8'(FRAME_LENGTH);
    localparam logic [7:0]  HDR_COMMAND = 8'h40;
    localparam logic [15:0] SUM_INIT    = 16'hFFFF;

    localparam logic [3:0]  MAX_CHANNELS = 4'd14;

    // Input operations
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_IDLE = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_HDR_ERR = 2'd1;
    localparam logic [1:0] KIND_SUM_ERR = 2'd2;
    localparam logic [1:0] KIND_LOST    = 2'd3;

    // Configuration registers
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOST_LIMIT    = 2'd1;

    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd14;
    localparam logic [7:0] LOST_LIMIT_RST    = 8'd20;

    // Frame check status, valid while the final byte is presented
    typedef struct packed {
        logic hdr_ok;
        logic sum_ok;
    } t_check;

endpackage

/* hw/rtl/ifr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_if
// Valid/ready channels of the iBUS frame receiver: input, result, config.
// ----------------------------------------------------------------------------
interface ifr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, op, data_byte, input ready);
    modport sink   (input valid, op, data_byte, output ready);
endinterface

interface ifr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        lost;
    logic        last;

    modport source (output valid, kind, channel_index, channel_value, lost, last,
                    input ready);
    modport sink   (input valid, kind, channel_index, channel_value, lost, last,
                    output ready);
endinterface

interface ifr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [7:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* hw/rtl/ifr_frame_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_frame_check
// Running header and checksum check over the bytes of one frame.
// ----------------------------------------------------------------------------
module ifr_frame_check (
    input  logic              i_clk,
    input  logic              i_wr,
    input  ifr_pkg::t_byte_idx i_pos,
    input  logic [7:0]        i_byte,
    output ifr_pkg::t_check   o_check
);
    import ifr_pkg::*;

    logic [15:0] r_sum;
    logic        r_hdr_ok;
    logic [7:0]  r_csum_lo;

    // Accumulate as bytes arrive; byte 0 restarts the sum and the header check
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            if (i_pos == HDR_LEN_POS) begin
                r_sum    <= SUM_INIT - {8'h00, i_byte};
                r_hdr_ok <= (i_byte == HDR_LENGTH);
            end else begin
                if (i_pos < SUM_BYTES) begin
                    r_sum <= r_sum - {8'h00, i_byte};
                end
                if (i_pos == HDR_CMD_POS) begin
                    r_hdr_ok <= r_hdr_ok & (i_byte == HDR_COMMAND);
                end
                if (i_pos == CSUM_LO_POS) begin
                    r_csum_lo <= i_byte;
                end
            end
        end
    end

    // Final byte carries the checksum high half
    assign o_check.hdr_ok = r_hdr_ok;
    assign o_check.sum_ok = ({i_byte, r_csum_lo} == r_sum);

endmodule

/* hw/rtl/ibus_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibus_frame_receiver
// iBUS frame parser: captures 32-byte frames after a line-idle event, checks
// header and checksum, and emits channel values, errors and lost status.
// ----------------------------------------------------------------------------
//  port    | dir | contents
//  --------+-----+------------------------------------------------------
//  i_in    | in  | op, data_byte (byte, line idle, lost poll)
//  o_out   | out | kind, channel_index, channel_value, lost, last
//  i_cfg   | in  | reg_index, wr_data (channel_count, lost_limit)
//
// Bytes, idle events and polls are taken only in S_IDLE; a poll or a bad frame loads
// the output register, and the next item is taken no earlier than the cycle in
// which that result is accepted.
// A valid frame emits n channels via S_READ_LO, S_READ_HI and S_SEND from the
// frame memory's single read port (a byte read in each READ state), no input meanwhile.
// Output stalls hold the sequencer; reset is synchronous, active low, and
// leaves the frame memory unwritten. Config writes are taken every cycle.
// ----------------------------------------------------------------------------
module ibus_frame_receiver (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifr_in_if.sink    i_in,
    ifr_out_if.source o_out,
    ifr_cfg_if.sink   i_cfg
);
    import ifr_pkg::*;

    `include "ibus_frame_receiver_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ_LO,
        S_READ_HI,
        S_SEND
    } t_state;

    t_state      r_state;
    logic        r_armed;
    t_byte_idx   r_byte_cnt;
    logic [7:0]  r_lost_cnt;
    logic [3:0]  r_chan_cnt_cfg;
    logic [7:0]  r_lost_limit;
    logic [3:0]  r_chan_idx;
    logic [3:0]  r_chan_n;
    logic [7:0]  r_lo;

    logic [7:0]  mem [FRAME_LENGTH];
    logic [7:0]  r_rd_data;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [3:0]  r_chan_index;
    logic [15:0] r_chan_value;
    logic        r_lost;
    logic        r_last;

    logic        out_free;
    logic        out_load;
    logic        in_fire;
    logic        byte_wr;
    logic        frame_done;
    logic [3:0]  n_chan;
    logic        rd_en;
    t_byte_idx   rd_addr;
    t_check      check;

    // Handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign byte_wr    = in_fire && (i_in.op == OP_BYTE) && r_armed;
    assign frame_done = byte_wr && (r_byte_cnt == LAST_POS);
    assign n_chan     = (r_chan_cnt_cfg > MAX_CHANNELS) ? MAX_CHANNELS : r_chan_cnt_cfg;

    // Output register gets a new result this cycle
    assign out_load = (r_state == S_SEND) ? out_free
                    : (in_fire && ((i_in.op == OP_POLL) ||
                                   (frame_done && !(check.hdr_ok && check.sum_ok))));

    // Header and checksum tracking
    ifr_frame_check u_check (
        .i_clk   (i_clk),
        .i_wr    (byte_wr),
        .i_pos   (r_byte_cnt),
        .i_byte  (i_in.data_byte),
        .o_check (check)
    );

    // Frame memory: one write port, one registered read port
    assign rd_en   = (r_state == S_READ_LO) || (r_state == S_READ_HI);
    assign rd_addr = (r_state == S_READ_HI) ? ({r_chan_idx, 1'b1} + FIRST_CHAN_POS)
                                            : ({r_chan_idx, 1'b0} + FIRST_CHAN_POS);

    always_ff @(posedge i_clk) begin
        if (byte_wr) begin
            mem[r_byte_cnt] <= i_in.data_byte;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control, sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_armed        <= 1'b0;
            r_byte_cnt     <= '0;
            r_lost_cnt     <= '0;
            r_chan_cnt_cfg <= CHANNEL_COUNT_RST;
            r_lost_limit   <= LOST_LIMIT_RST;
            r_chan_idx     <= '0;
            r_chan_n       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.reg_index)
                    CFG_CHANNEL_COUNT: r_chan_cnt_cfg <= i_cfg.wr_data[3:0];
                    CFG_LOST_LIMIT:    r_lost_limit   <= i_cfg.wr_data;
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (i_in.op)
                            OP_BYTE: begin
                                if (frame_done) begin
                                    r_armed    <= 1'b0;
                                    r_byte_cnt <= '0;
                                    r_lost_cnt <= '0;
                                    if (!check.hdr_ok || !check.sum_ok) begin
                                        r_out_valid  <= 1'b1;
                                        r_kind       <= check.hdr_ok ? KIND_SUM_ERR
                                                                     : KIND_HDR_ERR;
                                        r_chan_index <= '0;
                                        r_chan_value <= '0;
                                        r_lost       <= 1'b0;
                                        r_last       <= 1'b1;
                                    end else if (n_chan != '0) begin
                                        r_chan_n   <= n_chan;
                                        r_chan_idx <= '0;
                                        r_state    <= S_READ_LO;
                                    end
                                end else if (r_armed) begin
                                    r_byte_cnt <= r_byte_cnt + 1'b1;
                                end
                            end
                            OP_IDLE: begin
                                r_armed    <= 1'b1;
                                r_byte_cnt <= '0;
                            end
                            OP_POLL: begin
                                r_out_valid  <= 1'b1;
                                r_kind       <= KIND_LOST;
                                r_chan_index <= '0;
                                r_chan_value <= '0;
                                r_last       <= 1'b1;
                                if (r_lost_cnt < r_lost_limit) begin
                                    r_lost_cnt <= r_lost_cnt + 1'b1;
                                    r_lost     <= 1'b0;
                                end else begin
                                    r_lost     <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ_LO: begin
                    r_state <= S_READ_HI;
                end
                S_READ_HI: begin
                    // low byte of the channel is back from memory
                    r_lo    <= r_rd_data;
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_kind       <= KIND_CHANNEL;
                        r_chan_index <= r_chan_idx;
                        r_chan_value <= {r_rd_data, r_lo};
                        r_lost       <= 1'b0;
                        r_last       <= (r_chan_idx == r_chan_n - 1'b1);
                        if (r_chan_idx == r_chan_n - 1'b1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_chan_idx <= r_chan_idx + 1'b1;
                            r_state    <= S_READ_LO;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.channel_index = r_chan_index;
    assign o_out.channel_value = r_chan_value;
    assign o_out.lost          = r_lost;
    assign o_out.last          = r_last;

    // Assertions
    `IFR_ASSERT_IMPL(a_chan_idx_range, i_clk, i_rst_n, (r_state != S_IDLE), (r_chan_idx < r_chan_n))
    `IFR_ASSERT_IMPL(a_chan_last, i_clk, i_rst_n, (o_out.valid && o_out.kind == KIND_CHANNEL), (o_out.last == (o_out.channel_index == 4'(r_chan_n - 4'd1))))
    `IFR_ASSERT_IMPL(a_single_last, i_clk, i_rst_n, (o_out.valid && o_out.kind != KIND_CHANNEL), (o_out.last && o_out.channel_value == 16'd0))
    `IFR_ASSERT_NEXT(a_frame_disarm, i_clk, i_rst_n, frame_done, (!r_armed && r_byte_cnt == '0 && r_lost_cnt == 8'd0))

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the iBUS frame receiver. Streams line-idle events,
// frame bytes and lost polls into the input channel, from the second random
// phase on in bursts with random gaps, while the result side stalls in a mode
// drawn per phase. Results are compared with a cycle-free scoreboard model.
// ----------------------------------------------------------------------------
module tb;
    import ifr_pkg::*;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTLE_CYCLES  = 64;
    localparam int         RANDOM_ITEMS   = 110;
    localparam int         PHASE_ITEMS    = 20;
    localparam int         MAX_REPORTS    = 10;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [1:0] CFG_SPARE_2    = 2'd2;
    localparam logic [1:0] CFG_SPARE_3    = 2'd3;

    typedef enum {FRAME_CLEAN, FRAME_BAD_HEADER, FRAME_BAD_SUM} frame_flaw_t;
    typedef enum {STALL_NONE, STALL_SCATTER, STALL_PATTERN} stall_mode_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  channel_index;
        logic [15:0] channel_value;
        logic        lost;
        logic        last;
    } ibus_result_t;

    // Parser model plus queue of results still owed by the block
    class ibus_frame_tracker;
        logic [3:0]   channel_count;
        logic [7:0]   lost_limit;
        logic [7:0]   lost_polls;
        bit           armed;
        int unsigned  byte_pos;
        logic [7:0]   frame_mem [FRAME_LENGTH];
        ibus_result_t expected_results[$];
        int           mismatches;
        int           results_checked;
        int           frames_good;
        int           frames_hdr_bad;
        int           frames_sum_bad;
        int           polls_seen;

        function new();
            channel_count   = CHANNEL_COUNT_RST;
            lost_limit      = LOST_LIMIT_RST;
            lost_polls      = '0;
            armed           = 1'b0;
            byte_pos        = 0;
            mismatches      = 0;
            results_checked = 0;
            frames_good     = 0;
            frames_hdr_bad  = 0;
            frames_sum_bad  = 0;
            polls_seen      = 0;
        endfunction

        function void note_register(logic [1:0] index, logic [7:0] value);
            case (index)
                CFG_CHANNEL_COUNT: channel_count = value[3:0];
                CFG_LOST_LIMIT:    lost_limit = value;
                default: ;
            endcase
        endfunction

        function void owe(logic [1:0] kind, logic [3:0] idx, logic [15:0] value,
                          logic lost, logic last);
            ibus_result_t r;
            r.kind          = kind;
            r.channel_index = idx;
            r.channel_value = value;
            r.lost          = lost;
            r.last          = last;
            expected_results.push_back(r);
        endfunction

        // Header, checksum, then channel words of a completed capture
        function void judge_frame();
            logic [15:0] sum;
            logic [15:0] rx_sum;
            int          n;
            if (frame_mem[0] != HDR_LENGTH || frame_mem[1] != HDR_COMMAND) begin
                frames_hdr_bad++;
                owe(KIND_HDR_ERR, 4'd0, 16'd0, 1'b0, 1'b1);
                return;
            end
            sum = SUM_INIT;
            for (int i = 0; i < SUM_BYTES; i++)
                sum = sum - 16'(frame_mem[i]);
            rx_sum = {frame_mem[31], frame_mem[30]};
            if (rx_sum != sum) begin
                frames_sum_bad++;
                owe(KIND_SUM_ERR, 4'd0, 16'd0, 1'b0, 1'b1);
                return;
            end
            frames_good++;
            n = (channel_count > MAX_CHANNELS) ? int'(MAX_CHANNELS) : int'(channel_count);
            for (int i = 0; i < n; i++)
                owe(KIND_CHANNEL, 4'(i), {frame_mem[3 + 2 * i], frame_mem[2 + 2 * i]},
                    1'b0, (i == n - 1));
        endfunction

        // Accepted input transaction
        function void note_item(logic [1:0] op, logic [7:0] data);
            case (op)
                OP_BYTE: begin
                    if (armed) begin
                        frame_mem[byte_pos] = data;
                        byte_pos++;
                        if (byte_pos == FRAME_LENGTH) begin
                            armed      = 1'b0;
                            byte_pos   = 0;
                            lost_polls = '0;
                            judge_frame();
                        end
                    end
                end
                OP_IDLE: begin
                    armed    = 1'b1;
                    byte_pos = 0;
                end
                OP_POLL: begin
                    polls_seen++;
                    if (lost_polls < lost_limit) begin
                        lost_polls = lost_polls + 8'd1;
                        owe(KIND_LOST, 4'd0, 16'd0, 1'b0, 1'b1);
                    end else begin
                        owe(KIND_LOST, 4'd0, 16'd0, 1'b1, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string what, ibus_result_t want, ibus_result_t got);
            if (mismatches < MAX_REPORTS)
                $display("%s: expected kind %0d idx %0d value %h lost %b last %b, got kind %0d idx %0d value %h lost %b last %b",
                         what, want.kind, want.channel_index, want.channel_value,
                         want.lost, want.last, got.kind, got.channel_index,
                         got.channel_value, got.lost, got.last);
            mismatches++;
        endfunction

        // Accepted result transaction against the oldest expectation
        function void check_result(ibus_result_t got);
            ibus_result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.kind !== want.kind || got.channel_index !== want.channel_index ||
                got.channel_value !== want.channel_value || got.lost !== want.lost ||
                got.last !== want.last)
                report("mismatch", want, got);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ifr_in_if  in_if();
    ifr_out_if out_if();
    ifr_cfg_if cfg_if();

    ibus_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    ibus_frame_tracker tracker = new();

    rx_item_t     item_feed[$];
    rx_item_t     next_item;
    ibus_result_t seen;
    int           pushed_count   = 0;
    int           accepted_count = 0;
    int           random_items   = 0;
    int           settings_seen  = 0;
    bit           in_taken       = 1'b0;
    bit           gaps_on        = 1'b0;
    int           burst_left     = 1;
    int           gap_left       = 0;
    stall_mode_t  stall_mode     = STALL_NONE;
    logic [15:0]  stall_pattern  = 16'h0F3C;
    logic [3:0]   stall_pos      = 4'd0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Input sender: bursts of transactions separated by random gaps when enabled
    always @(negedge i_clk) begin
        if (!in_if.valid || in_taken) begin
            if (gap_left > 0) begin
                in_if.valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (item_feed.size() > 0) begin
                next_item = item_feed.pop_front();
                in_if.valid     <= 1'b1;
                in_if.op        <= next_item.op;
                in_if.data_byte <= next_item.data;
                if (gaps_on) begin
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        gap_left   = $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 24);
                    end
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver stalls
    always @(negedge i_clk) begin
        case (stall_mode)
            STALL_NONE:    out_if.ready <= 1'b1;
            STALL_SCATTER: out_if.ready <= ($urandom_range(0, 3) != 0);
            default: begin
                out_if.ready <= stall_pattern[stall_pos];
                stall_pos = stall_pos + 4'd1;
                if (stall_pos == 4'd0)
                    stall_pattern = 16'($urandom);
            end
        endcase
    end

    // Monitor: results first, then config and input transactions
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                seen.kind          = out_if.kind;
                seen.channel_index = out_if.channel_index;
                seen.channel_value = out_if.channel_value;
                seen.lost          = out_if.lost;
                seen.last          = out_if.last;
                tracker.check_result(seen);
            end
            if (cfg_if.valid && cfg_if.ready)
                tracker.note_register(cfg_if.reg_index, cfg_if.wr_data);
            if (in_if.valid && in_if.ready) begin
                tracker.note_item(in_if.op, in_if.data_byte);
                in_taken = 1'b1;
                accepted_count++;
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_item(logic [1:0] op, logic [7:0] data);
        rx_item_t it;
        it.op   = op;
        it.data = data;
        item_feed.push_back(it);
        pushed_count++;
        if (op != OP_UNUSED)
            random_items++;
    endtask

    // Idle event followed by one 32-byte frame, optionally with a poll inside
    task automatic queue_frame(frame_flaw_t flaw, bit extremes, bit poll_inside);
        logic [7:0]  f [FRAME_LENGTH];
        logic [15:0] sum;
        int          poll_at;
        int          pos;
        f[0] = HDR_LENGTH;
        f[1] = HDR_COMMAND;
        for (int i = 2; i < SUM_BYTES; i++)
            f[i] = extremes ? (((i / 2) % 2 == 1) ? 8'h00 : 8'hFF) : 8'($urandom);
        sum = SUM_INIT;
        for (int i = 0; i < SUM_BYTES; i++)
            sum = sum - 16'(f[i]);
        if (flaw == FRAME_BAD_SUM)
            sum = sum ^ 16'($urandom_range(1, 65535));
        f[30] = sum[7:0];
        f[31] = sum[15:8];
        if (flaw == FRAME_BAD_HEADER) begin
            pos = $urandom_range(0, 1);
            f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
        end
        poll_at = poll_inside ? $urandom_range(1, FRAME_LENGTH - 1) : -1;
        push_item(OP_IDLE, 8'($urandom));
        for (int i = 0; i < FRAME_LENGTH; i++) begin
            if (i == poll_at)
                push_item(OP_POLL, 8'($urandom));
            push_item(OP_BYTE, f[i]);
        end
    endtask

    // Hold off until everything sent is taken and every result is back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (accepted_count != pushed_count || tracker.expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [7:0] value);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= index;
        cfg_if.wr_data   <= value;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [3:0] count, logic [7:0] limit);
        write_reg(CFG_CHANNEL_COUNT, {4'($urandom), count});
        write_reg(CFG_LOST_LIMIT, limit);
        settings_seen++;
    endtask

    // One phase of mostly well-formed frames with polls, breaks and noise
    task automatic run_phase();
        int start;
        int pick;
        start = random_items;
        repeat ($urandom_range(1, 4)) push_item(OP_POLL, 8'($urandom));
        while (random_items - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_frame(FRAME_CLEAN, ($urandom_range(0, 7) == 0),
                            ($urandom_range(0, 4) == 0));
            else if (pick < 60)
                queue_frame(FRAME_BAD_HEADER, 1'b0, 1'b0);
            else if (pick < 70)
                queue_frame(FRAME_BAD_SUM, 1'b0, ($urandom_range(0, 3) == 0));
            else if (pick < 82)
                repeat ($urandom_range(1, 3)) push_item(OP_POLL, 8'($urandom));
            else if (pick < 92) begin
                // truncated capture, dropped by whatever idle comes next
                push_item(OP_IDLE, 8'($urandom));
                repeat ($urandom_range(1, FRAME_LENGTH - 1))
                    push_item(OP_BYTE, 8'($urandom));
            end else begin
                push_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    // Main sequence
    initial begin
        int phase;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.op         = OP_BYTE;
        in_if.data_byte  = 8'h00;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = CFG_CHANNEL_COUNT;
        cfg_if.wr_data   = 8'h00;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: polls, stray byte, unused op, restart mid-frame, clean and error frames
        push_item(OP_POLL, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_UNUSED, 8'hFF);
        push_item(OP_IDLE, 8'h00);
        push_item(OP_BYTE, HDR_LENGTH);
        push_item(OP_BYTE, HDR_COMMAND);
        push_item(OP_BYTE, 8'h55);
        queue_frame(FRAME_CLEAN, 1'b1, 1'b0);
        queue_frame(FRAME_BAD_HEADER, 1'b0, 1'b0);
        queue_frame(FRAME_BAD_SUM, 1'b0, 1'b1);
        push_item(OP_POLL, 8'hFF);
        wait_idle();
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'h00);

        // Random phases, extremes of the registers first
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            case (phase)
                0: apply_setting(4'd0, 8'd0);
                1: apply_setting(4'd15, 8'd255);
                2: apply_setting(4'd1, 8'd2);
                3: apply_setting(4'd14, 8'd1);
                default: apply_setting(4'($urandom_range(0, 15)),
                                       ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                   : 8'($urandom_range(0, 5)));
            endcase
            gaps_on    = (phase != 0);
            burst_left = $urandom_range(1, 24);
            stall_mode = (phase == 0) ? STALL_NONE : stall_mode_t'($urandom_range(0, 2));
            run_phase();
            phase++;
        end
        wait_idle();

        $display("Covered %0d clean frames, %0d header faults, %0d checksum faults, %0d polls",
                 tracker.frames_good, tracker.frames_hdr_bad, tracker.frames_sum_bad,
                 tracker.polls_seen);
        $display("%0d results checked over %0d register settings, %0d mismatches",
                 tracker.results_checked, settings_seen, tracker.mismatches);
        if (tracker.expected_results.size() != 0)
            $display("%0d expected results never arrived", tracker.expected_results.size());
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* ibus_frame_receiver.f */
+incdir+hw/rtl
hw/rtl/ifr_pkg.sv
hw/rtl/ifr_if.sv
hw/rtl/ifr_frame_check.sv
hw/rtl/ibus_frame_receiver.sv
tb/tb.sv
